### design/sctu_pkg.sv
// Package for the encoder set countdown timer: codes, result type, time
// constants and the minute adjust and default check functions.
// No dependencies.
package sctu_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_SET   = 2'd1,
    MODE_RUN   = 2'd2,
    MODE_ALARM = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_NUM  = 2'd0,
    KIND_IDLE = 2'd1,
    KIND_ALT  = 2'd2,
    KIND_ZERO = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_TURN   = 2'd1,
    REQ_BUTTON = 2'd2
  } req_t;

  localparam logic CFG_DEFAULT_MINUTES = 1'b0;
  localparam logic CFG_TICKS_PER_TENTH = 1'b1;

  localparam logic [6:0]  MINUTES_FALLBACK = 7'd30;
  localparam logic [6:0]  MINUTES_MAX_DEFAULT = 7'd95;
  localparam logic [15:0] TICKS_RESET = 16'd3221;

  localparam logic [5:0] IDLE_RELOAD  = 6'd40;
  localparam logic [5:0] IDLE_ALT     = 6'd20;
  localparam logic [5:0] RUN_RELOAD   = 6'd18;
  localparam logic [5:0] RUN_NUM      = 6'd12;
  localparam logic [5:0] ALARM_RELOAD = 6'd8;
  localparam logic [5:0] ALARM_ALT    = 6'd4;
  localparam logic [3:0] TENTHS_PER_SEC = 4'd10;
  localparam logic [5:0] SECS_PER_MIN   = 6'd60;

  typedef struct packed {
    kind_t      kind;
    logic [6:0] number;
    mode_t      mode;
    logic       alarm;
  } result_t;

  function automatic logic [6:0] valid_default(input logic [6:0] v);
    return (v == 7'd0 || v > MINUTES_MAX_DEFAULT) ? MINUTES_FALLBACK : v;
  endfunction

  // 1 per detent below 30, 5 per detent from 30 up; clamp into 1..99
  function automatic logic [6:0] adjust_minutes(input logic [6:0] cur,
                                                input logic signed [4:0] w);
    logic signed [9:0] c;
    logic signed [9:0] ws;
    logic signed [9:0] w5;
    c  = signed'({3'b000, cur});
    ws = 10'(w);
    w5 = (ws <<< 2) + ws;
    if (c > 10'sd29 && w > 5'sd0) c = c + w5;
    if (c < 10'sd30) c = c + ws;
    if (c == 10'sd30 && w < 5'sd0) c = c + ws;
    if (c > 10'sd30 && w < 5'sd0) c = c + w5;
    if (c > 10'sd99) c = 10'sd95;
    if (c < 10'sd1) c = 10'sd1;
    return c[6:0];
  endfunction

endpackage

### design/encoder_set_countdown_timer_unit.sv
// Top level of the encoder set countdown timer: stream ports, config port,
// core update and output buffer. Depends on sctu_pkg, sctu_core, sctu_outbuf.
//
// Takes one word per clock cycle while s_tready is high (base tick, encoder
// turn or button press) and returns one result word per input word, held
// in a two-entry output buffer; s_tready drops only when both entries are
// full. All state for a word is updated in a single combinational pass in
// sctu_core. Config writes are always accepted and take effect the next cycle.
module encoder_set_countdown_timer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [4:0] turn_steps, [7:5] zero
  input  logic [1:0]  s_tuser,   // [1:0] req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [6:0] display_number, [8:7] timer_mode,
                                 // [9] alarm_on, [15:10] zero
  output logic [1:0]  m_tuser,   // [1:0] display_kind
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import sctu_pkg::*;

  logic    fire;
  logic    can_push;
  result_t res;
  result_t out_res;

  assign s_tready  = can_push;
  assign fire      = s_tvalid && can_push;
  assign cfg_ready = 1'b1;

  sctu_core u_core (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .req_type   (s_tuser),
    .turn_steps (signed'(s_tdata[4:0])),
    .cfg_fire   (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .res        (res)
  );

  sctu_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (fire),
    .push_data (res),
    .can_push  (can_push),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_res)
  );

  assign m_tdata = {6'd0, out_res.alarm, out_res.mode, out_res.number};
  assign m_tuser = out_res.kind;

endmodule

### design/sctu_core.sv
// Timer state and single pass update for one word: prescaler, blink counter,
// countdown, mode control and display content. Depends on sctu_pkg.
module sctu_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [1:0]        req_type,
  input  logic signed [4:0] turn_steps,
  input  logic              cfg_fire,
  input  logic              cfg_index,
  input  logic [15:0]       cfg_data,
  output sctu_pkg::result_t res
);
  import sctu_pkg::*;

  mode_t       mode, mode_next;
  logic [6:0]  set_minutes, set_minutes_next;
  logic [6:0]  left_minutes, left_minutes_next;
  logic [5:0]  second_count, second_count_next;
  logic [3:0]  tenth_count, tenth_count_next;
  logic [15:0] prescale_count, prescale_count_next;
  logic        tenth_pending, tenth_pending_next;
  logic [5:0]  blink_count, blink_count_next;
  kind_t       shown_kind, shown_kind_next;
  logic [6:0]  shown_number, shown_number_next;
  logic        alarm_level, alarm_level_next;
  logic [15:0] ticks_per_tenth;

  always_comb begin
    logic [15:0] lim;
    logic [16:0] pinc;
    mode_next           = mode;
    set_minutes_next    = set_minutes;
    left_minutes_next   = left_minutes;
    second_count_next   = second_count;
    tenth_count_next    = tenth_count;
    prescale_count_next = prescale_count;
    tenth_pending_next  = tenth_pending;
    blink_count_next    = blink_count;
    shown_kind_next     = shown_kind;
    shown_number_next   = shown_number;
    alarm_level_next    = alarm_level;
    lim  = (ticks_per_tenth == 16'd0) ? 16'd1 : ticks_per_tenth;
    pinc = {1'b0, prescale_count} + 17'd1;

    case (req_type)
      REQ_TICK: begin
        if (prescale_count == 16'd0 && blink_count != 6'd0)
          blink_count_next = blink_count - 6'd1;
        if (pinc >= {1'b0, lim}) begin
          prescale_count_next = 16'd0;
          tenth_pending_next  = 1'b1;
        end else begin
          prescale_count_next = pinc[15:0];
        end
      end
      REQ_TURN: begin
        if (mode == MODE_IDLE) begin
          shown_kind_next   = KIND_NUM;
          shown_number_next = set_minutes;
          mode_next         = MODE_SET;
        end else if (mode == MODE_SET) begin
          set_minutes_next  = adjust_minutes(set_minutes, turn_steps);
          shown_kind_next   = KIND_NUM;
          shown_number_next = set_minutes_next;
        end else if (mode == MODE_RUN) begin
          blink_count_next  = RUN_NUM;
          left_minutes_next = adjust_minutes(left_minutes, turn_steps);
        end
      end
      REQ_BUTTON: begin
        if (mode == MODE_IDLE) begin
          mode_next         = MODE_SET;
          shown_kind_next   = KIND_NUM;
          shown_number_next = set_minutes;
        end else if (mode == MODE_SET) begin
          second_count_next = 6'd0;
          left_minutes_next = set_minutes;
          mode_next         = MODE_RUN;
        end else if (mode == MODE_RUN) begin
          mode_next         = MODE_IDLE;
          shown_kind_next   = KIND_IDLE;
          shown_number_next = 7'd0;
        end else begin
          alarm_level_next  = 1'b0;
          shown_kind_next   = KIND_IDLE;
          shown_number_next = 7'd0;
          mode_next         = MODE_IDLE;
        end
      end
      default: ;
    endcase

    // display rules and countdown, applied after every word
    if (mode_next == MODE_IDLE) begin
      if (blink_count_next == 6'd0) blink_count_next = IDLE_RELOAD;
      if (blink_count_next == IDLE_RELOAD) begin
        shown_kind_next   = KIND_IDLE;
        shown_number_next = 7'd0;
      end
      if (blink_count_next == IDLE_ALT) begin
        shown_kind_next   = KIND_ALT;
        shown_number_next = 7'd0;
      end
    end
    if (mode_next == MODE_RUN) begin
      if (blink_count_next == 6'd0) blink_count_next = RUN_RELOAD;
      if (blink_count_next == RUN_RELOAD) begin
        shown_kind_next   = KIND_ALT;
        shown_number_next = 7'd0;
      end
      if (blink_count_next == RUN_NUM) begin
        shown_kind_next   = KIND_NUM;
        shown_number_next = left_minutes_next;
      end
      if (tenth_pending_next) begin
        tenth_pending_next = 1'b0;
        tenth_count_next   = tenth_count_next + 4'd1;
        if (tenth_count_next == TENTHS_PER_SEC) begin
          second_count_next = second_count_next + 6'd1;
          if (second_count_next == SECS_PER_MIN) begin
            second_count_next = 6'd0;
            left_minutes_next = left_minutes_next - 7'd1;
            if (left_minutes_next == 7'd0) begin
              alarm_level_next = 1'b1;
              mode_next        = MODE_ALARM;
            end
          end
          tenth_count_next = 4'd0;
        end
      end
    end
    if (mode_next == MODE_ALARM) begin
      if (blink_count_next == 6'd0) blink_count_next = ALARM_RELOAD;
      if (blink_count_next == ALARM_RELOAD) begin
        shown_kind_next   = KIND_ZERO;
        shown_number_next = 7'd0;
      end
      if (blink_count_next == ALARM_ALT) begin
        shown_kind_next   = KIND_ALT;
        shown_number_next = 7'd0;
      end
    end
  end

  assign res.kind   = shown_kind_next;
  assign res.number = shown_number_next;
  assign res.mode   = mode_next;
  assign res.alarm  = alarm_level_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= MODE_IDLE;
      set_minutes     <= MINUTES_FALLBACK;
      left_minutes    <= 7'd0;
      second_count    <= 6'd0;
      tenth_count     <= 4'd0;
      prescale_count  <= 16'd0;
      tenth_pending   <= 1'b0;
      blink_count     <= 6'd0;
      shown_kind      <= KIND_IDLE;
      shown_number    <= 7'd0;
      alarm_level     <= 1'b0;
      ticks_per_tenth <= TICKS_RESET;
    end else begin
      if (fire) begin
        mode           <= mode_next;
        left_minutes   <= left_minutes_next;
        second_count   <= second_count_next;
        tenth_count    <= tenth_count_next;
        prescale_count <= prescale_count_next;
        tenth_pending  <= tenth_pending_next;
        blink_count    <= blink_count_next;
        shown_kind     <= shown_kind_next;
        shown_number   <= shown_number_next;
        alarm_level    <= alarm_level_next;
      end
      // a default minutes write wins over the word's own update
      if (cfg_fire && cfg_index == CFG_DEFAULT_MINUTES) begin
        set_minutes <= valid_default(cfg_data[6:0]);
      end else if (fire) begin
        set_minutes <= set_minutes_next;
      end
      if (cfg_fire && cfg_index == CFG_TICKS_PER_TENTH) begin
        ticks_per_tenth <= cfg_data;
      end
    end
  end

  a_alarm_mode: assert property (@(posedge clk) disable iff (rst)
    alarm_level == (mode == MODE_ALARM))
    else $error("alarm level out of step with alarm mode");
  a_number_kind: assert property (@(posedge clk) disable iff (rst)
    shown_number != 7'd0 |-> shown_kind == KIND_NUM)
    else $error("number shown with a pattern kind");
  a_set_range: assert property (@(posedge clk) disable iff (rst)
    set_minutes >= 7'd1 && set_minutes <= 7'd99)
    else $error("minutes setting out of range");
  a_mode_hold: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(mode))
    else $error("mode changed without a word");

endmodule

### design/sctu_outbuf.sv
// Two-entry output buffer: result register plus skid stage, so a new word
// is taken while a result waits. Depends on sctu_pkg.
module sctu_outbuf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  sctu_pkg::result_t push_data,
  output logic              can_push,
  output logic              out_valid,
  input  logic              out_ready,
  output sctu_pkg::result_t out_data
);
  import sctu_pkg::*;

  logic    head_valid;
  result_t head;
  logic    skid_valid;
  result_t skid;
  logic    pop;

  assign pop       = head_valid && out_ready;
  assign can_push  = !skid_valid;
  assign out_valid = head_valid;
  assign out_data  = head;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        head       <= skid;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!head_valid || pop) begin
        head       <= push_data;
        head_valid <= 1'b1;
      end else begin
        skid       <= push_data;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      head_valid <= 1'b0;
    end
  end

  a_skid_behind_head: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> head_valid)
    else $error("skid entry without head entry");
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    push |-> !skid_valid)
    else $error("word pushed into full buffer");
  a_skid_moves_up: assert property (@(posedge clk) disable iff (rst)
    skid_valid && pop |=> head_valid && !skid_valid)
    else $error("skid entry lost on pop");

endmodule

### sim/countdown_checker.sv
// Checker for the countdown timer unit: watches the config, input and result
// channels, predicts each result word and compares it field by field.
// Depends on sctu_pkg.
module countdown_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  input  logic            s_tready,
  input  logic [7:0]      s_tdata,
  input  logic [1:0]      s_tuser,
  input  logic            m_tvalid,
  input  logic            m_tready,
  input  logic [15:0]     m_tdata,
  input  logic [1:0]      m_tuser,
  input  logic            cfg_valid,
  input  logic            cfg_ready,
  input  logic            cfg_index,
  input  logic [15:0]     cfg_data,
  output int              errors,
  output int              waiting,
  output sctu_pkg::mode_t model_mode,
  output int              checked,
  output int              alarms
);
  import sctu_pkg::*;

  logic [6:0]  dflt_min;
  logic [15:0] tick_div;

  mode_t       md;
  logic [6:0]  set_min;
  logic [6:0]  left_min;
  logic [5:0]  sec_cnt;
  logic [3:0]  tenth_cnt;
  logic [15:0] pre_cnt;
  logic        tenth_pend;
  logic [5:0]  blink;
  kind_t       shown;
  logic [6:0]  shown_num;
  logic        alarm_lvl;

  result_t status_q[$];
  result_t want;
  result_t got;
  int      err_n;
  int      chk_n;
  int      alarm_n;

  function automatic logic [6:0] startup_minutes(input logic [6:0] v);
    if (v == 7'd0 || v > 7'd95)
      return 7'd30;
    return v;
  endfunction

  // coarse steps of five from 30 up, single steps below; clamp 1..99 (over -> 95)
  function automatic logic [6:0] step_minutes(input logic [6:0] cur,
                                              input logic signed [4:0] steps);
    int c;
    int w;
    c = int'(cur);
    w = int'(steps);
    if (c > 29 && w > 0) c = c + 5 * w;
    if (c < 30) c = c + w;
    if (c == 30 && w < 0) c = c + w;
    if (c > 30 && w < 0) c = c + 5 * w;
    if (c > 99) c = 95;
    if (c < 1) c = 1;
    return 7'(c);
  endfunction

  task automatic show_on(input kind_t k, input logic [6:0] n);
    shown = k;
    shown_num = (k == KIND_NUM) ? n : 7'd0;
  endtask

  task automatic advance_timer(input logic [1:0] req, input logic signed [4:0] steps,
                               output result_t r);
    int lim;
    int pc;
    case (req)
      REQ_TICK: begin
        lim = (tick_div == 16'd0) ? 1 : int'(tick_div);
        if (pre_cnt == 16'd0 && blink != 6'd0) blink = blink - 6'd1;
        pc = int'(pre_cnt) + 1;
        if (pc >= lim) begin
          pc = 0;
          tenth_pend = 1'b1;
        end
        pre_cnt = 16'(pc);
      end
      REQ_TURN: begin
        case (md)
          MODE_IDLE: begin
            show_on(KIND_NUM, set_min);
            md = MODE_SET;
          end
          MODE_SET: begin
            set_min = step_minutes(set_min, steps);
            show_on(KIND_NUM, set_min);
          end
          MODE_RUN: begin
            blink = 6'd12;
            left_min = step_minutes(left_min, steps);
          end
          default: ;
        endcase
      end
      REQ_BUTTON: begin
        case (md)
          MODE_IDLE: begin
            md = MODE_SET;
            show_on(KIND_NUM, set_min);
          end
          MODE_SET: begin
            sec_cnt = 6'd0;
            left_min = set_min;
            md = MODE_RUN;
          end
          MODE_RUN: begin
            md = MODE_IDLE;
            show_on(KIND_IDLE, 7'd0);
          end
          default: begin
            alarm_lvl = 1'b0;
            show_on(KIND_IDLE, 7'd0);
            md = MODE_IDLE;
          end
        endcase
      end
      default: ;
    endcase

    if (md == MODE_IDLE) begin
      if (blink == 6'd0) blink = 6'd40;
      if (blink == 6'd40) show_on(KIND_IDLE, 7'd0);
      if (blink == 6'd20) show_on(KIND_ALT, 7'd0);
    end
    if (md == MODE_RUN) begin
      if (blink == 6'd0) blink = 6'd18;
      if (blink == 6'd18) show_on(KIND_ALT, 7'd0);
      if (blink == 6'd12) show_on(KIND_NUM, left_min);
      if (tenth_pend) begin
        tenth_pend = 1'b0;
        tenth_cnt = tenth_cnt + 4'd1;
        if (tenth_cnt == 4'd10) begin
          sec_cnt = sec_cnt + 6'd1;
          if (sec_cnt == 6'd60) begin
            sec_cnt = 6'd0;
            left_min = left_min - 7'd1;
            if (left_min == 7'd0) begin
              alarm_lvl = 1'b1;
              md = MODE_ALARM;
              alarm_n++;
            end
          end
          tenth_cnt = 4'd0;
        end
      end
    end
    if (md == MODE_ALARM) begin
      if (blink == 6'd0) blink = 6'd8;
      if (blink == 6'd8) show_on(KIND_ZERO, 7'd0);
      if (blink == 6'd4) show_on(KIND_ALT, 7'd0);
    end

    r.kind = shown;
    r.number = shown_num;
    r.mode = md;
    r.alarm = alarm_lvl;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      dflt_min = 7'd30;
      tick_div = 16'd3221;
      md = MODE_IDLE;
      set_min = startup_minutes(dflt_min);
      left_min = 7'd0;
      sec_cnt = 6'd0;
      tenth_cnt = 4'd0;
      pre_cnt = 16'd0;
      tenth_pend = 1'b0;
      blink = 6'd0;
      shown = KIND_IDLE;
      shown_num = 7'd0;
      alarm_lvl = 1'b0;
      status_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_DEFAULT_MINUTES) begin
          dflt_min = cfg_data[6:0];
          set_min = startup_minutes(dflt_min);
        end else begin
          tick_div = cfg_data;
        end
      end
      if (s_tvalid && s_tready) begin
        advance_timer(s_tuser, s_tdata[4:0], want);
        status_q.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        got.kind = kind_t'(m_tuser);
        got.number = m_tdata[6:0];
        got.mode = mode_t'(m_tdata[8:7]);
        got.alarm = m_tdata[9];
        chk_n++;
        if (status_q.size() == 0) begin
          err_n++;
          if (err_n <= 10)
            $display("word %0d: unexpected result kind %0d num %0d mode %0d alarm %0d",
                     chk_n, got.kind, got.number, got.mode, got.alarm);
        end else begin
          want = status_q.pop_front();
          if (got.kind !== want.kind || got.number !== want.number ||
              got.mode !== want.mode || got.alarm !== want.alarm) begin
            err_n++;
            if (err_n <= 10)
              $display({"word %0d: expected kind %0d num %0d mode %0d alarm %0d,",
                        " got kind %0d num %0d mode %0d alarm %0d"},
                       chk_n, want.kind, want.number, want.mode, want.alarm,
                       got.kind, got.number, got.mode, got.alarm);
          end
        end
      end
    end
    errors <= err_n;
    waiting <= status_q.size();
    model_mode <= md;
    checked <= chk_n;
    alarms <= alarm_n;
  end

endmodule

### sim/tb.sv
// Testbench top for the countdown timer unit: clock, reset, config writes,
// directed and random input words, random result stalls and the verdict.
// Depends on sctu_pkg, encoder_set_countdown_timer_unit, countdown_checker.
module tb;
  import sctu_pkg::*;

  localparam logic [1:0] REQ_NONE = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 8;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [15:0] cfg_data;

  int    errors;
  int    waiting;
  mode_t model_mode;
  int    checked;
  int    alarms;
  int    cycles = 0;
  int    words_sent = 0;
  bit    calm_tx = 1'b0;

  encoder_set_countdown_timer_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  countdown_checker chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .errors(errors), .waiting(waiting), .model_mode(model_mode),
    .checked(checked), .alarms(alarms)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[encoder_set_countdown_timer_unit] ERROR");
      $finish;
    end
  end

  // result side: random stalls, with stretches of none
  initial begin
    int gap;
    bit calm_rx;
    m_tready = 1'b0;
    calm_rx = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) calm_rx = !calm_rx;
      gap = calm_rx ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  function automatic int rand_steps();
    if ($urandom_range(0, 4) != 0)
      return int'($urandom_range(0, 16)) - 8;
    return int'($urandom_range(0, 31));
  endfunction

  task automatic send_word(input logic [1:0] req, input int steps);
    int gap;
    if ($urandom_range(0, 39) == 0) calm_tx = !calm_tx;
    gap = calm_tx ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= req;
    s_tdata <= {3'b000, 5'(steps)};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    words_sent++;
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_settings(input logic [15:0] minutes, input logic [15:0] div);
    drain_results();
    write_reg(CFG_DEFAULT_MINUTES, minutes);
    write_reg(CFG_TICKS_PER_TENTH, div);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // set one minute, start, tick until the alarm fires, then clear it
  task automatic run_to_alarm();
    int tries;
    drain_results();
    while (model_mode != MODE_SET) begin
      send_word(REQ_BUTTON, rand_steps());
      drain_results();
    end
    repeat (3) send_word(REQ_TURN, -16);
    send_word(REQ_BUTTON, rand_steps());
    send_word(REQ_TURN, -1);
    tries = 0;
    do begin
      repeat (10) send_word(REQ_TICK, rand_steps());
      drain_results();
      tries++;
    end while (model_mode != MODE_ALARM && tries < 80);
    repeat (12) send_word(REQ_TICK, rand_steps());
    send_word(REQ_TURN, rand_steps());
    send_word(REQ_NONE, rand_steps());
    send_word(REQ_BUTTON, rand_steps());
  endtask

  task automatic random_phase(input int n);
    int start;
    int p;
    int req_pick;
    start = words_sent;
    while (words_sent - start < n) begin
      p = $urandom_range(0, 99);
      if (p < 50) begin
        repeat ($urandom_range(4, 16)) begin
          req_pick = $urandom_range(0, 99);
          if (req_pick < 55) send_word(REQ_TICK, rand_steps());
          else if (req_pick < 78) send_word(REQ_TURN, rand_steps());
          else if (req_pick < 94) send_word(REQ_BUTTON, rand_steps());
          else send_word(REQ_NONE, rand_steps());
        end
      end else if (p < 75) begin
        send_word(REQ_BUTTON, rand_steps());
        repeat ($urandom_range(1, 5)) send_word(REQ_TURN, rand_steps());
        send_word(REQ_BUTTON, rand_steps());
      end else if (p < 92) begin
        repeat ($urandom_range(8, 40)) send_word(REQ_TICK, rand_steps());
      end else begin
        drain_results();
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = 8'd0;
    s_tuser = REQ_TICK;
    cfg_valid = 1'b0;
    cfg_index = CFG_DEFAULT_MINUTES;
    cfg_data = 16'd0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset settings, minute adjust edges, idle, set and run modes by button
    send_word(REQ_NONE, 15);
    send_word(REQ_TICK, -16);
    send_word(REQ_TURN, 8);
    send_word(REQ_TURN, 8);
    send_word(REQ_TURN, 8);    // over 99 -> 95
    send_word(REQ_TURN, -8);
    send_word(REQ_TURN, -8);
    send_word(REQ_TURN, -8);
    send_word(REQ_TURN, -8);   // below 1 -> 1
    send_word(REQ_TURN, 15);
    send_word(REQ_TURN, -16);
    send_word(REQ_TURN, 15);
    send_word(REQ_TURN, 14);
    send_word(REQ_TURN, -1);   // from exactly 30 going down
    send_word(REQ_TURN, 1);
    send_word(REQ_TURN, 1);
    send_word(REQ_BUTTON, 0);
    send_word(REQ_TURN, -16);  // running minutes clamp
    send_word(REQ_TICK, 0);
    send_word(REQ_NONE, 0);
    send_word(REQ_BUTTON, 0);
    send_word(REQ_BUTTON, 0);
    send_word(REQ_BUTTON, 0);
    send_word(REQ_BUTTON, 0);
    random_phase(20);

    load_settings(16'd1, 16'd1);
    run_to_alarm();
    random_phase(15);

    load_settings(16'hFF80, 16'd0);
    random_phase(10);

    load_settings(16'd95, 16'd2);
    random_phase(10);

    load_settings(16'h007F, 16'hFFFF);
    random_phase(10);

    load_settings(16'd96, 16'd3);
    random_phase(10);

    load_settings(16'($urandom_range(1, 127)), 16'($urandom_range(1, 6)));
    random_phase(10);

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d input words over 7 register settings:", words_sent);
    $display("  %0d results checked, %0d alarms.", checked, alarms);
    if (errors == 0 && waiting == 0) begin
      $display("[encoder_set_countdown_timer_unit] OK");
    end else begin
      $display("[encoder_set_countdown_timer_unit] ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
design/sctu_pkg.sv
design/sctu_core.sv
design/sctu_outbuf.sv
design/encoder_set_countdown_timer_unit.sv
sim/countdown_checker.sv
sim/tb.sv
